### rtl/core/chatan_pkg.sv
`timescale 1ns / 1ps

package chatan_pkg;

    localparam int ANGLE_STAGES    = 16;
    localparam int COMPONENT_WIDTH = 16;

    localparam int FIELD_W     = 16;
    localparam int HEADING_W   = 16;
    localparam int GUARD_BITS  = 8;
    localparam int TABLE_LEN   = 24;
    localparam int DEG_FRAC    = 20;
    localparam int OUT_SHIFT   = 13;

    localparam int NUM_ROT = (ANGLE_STAGES < TABLE_LEN) ? ANGLE_STAGES : TABLE_LEN;

    // headroom for the 180 degree flip, the vector length and the cordic gain
    localparam int XY_W    = COMPONENT_WIDTH + GUARD_BITS + 3;
    localparam int ANGLE_W = 31;
    localparam int OUT_Q_W = ANGLE_W - 1 - OUT_SHIFT;

    localparam logic signed [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(180 * (2 ** DEG_FRAC));
    localparam logic signed [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360 * (2 ** DEG_FRAC));
    localparam logic signed [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(2 ** (OUT_SHIFT - 1));
    localparam logic [OUT_Q_W-1:0] FULL_TURN_OUT = OUT_Q_W'(46080);

    // pre-processing stage, rotation stages, two output stages
    localparam int LATENCY = NUM_ROT + 3;

    // atan(2^-i) in degrees, scaled by 2^20
    localparam logic signed [ANGLE_W-1:0] ATAN_DEG_Q20 [0:TABLE_LEN-1] = '{
        ANGLE_W'(47185920), ANGLE_W'(27855475), ANGLE_W'(14718068), ANGLE_W'(7471121),
        ANGLE_W'(3750058),  ANGLE_W'(1876857),  ANGLE_W'(938658),   ANGLE_W'(469357),
        ANGLE_W'(234682),   ANGLE_W'(117342),   ANGLE_W'(58671),    ANGLE_W'(29335),
        ANGLE_W'(14668),    ANGLE_W'(7334),     ANGLE_W'(3667),     ANGLE_W'(1833),
        ANGLE_W'(917),      ANGLE_W'(458),      ANGLE_W'(229),      ANGLE_W'(115),
        ANGLE_W'(57),       ANGLE_W'(29),       ANGLE_W'(14),       ANGLE_W'(7)
    };

endpackage

### rtl/core/compass_heading_atan2_top.sv
`timescale 1ns / 1ps

// Compass heading atan2(field_y, field_x) in 1/128 degree, 0 to 46079, from a fully
// unrolled vectoring cordic. An item is taken in every cycle (busy stays low) and its
// heading comes out with a one-cycle done strobe after the pipeline: one stage for the
// sign fold, one per micro-rotation and two for wrap and rounding. The receiver cannot
// stall, so results must be taken when done is high. A zero vector gives 0 and a
// heading that rounds to 360 degrees gives 0.
module compass_heading_atan2_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [chatan_pkg::FIELD_W-1:0] field_x,
    input  logic signed [chatan_pkg::FIELD_W-1:0] field_y,
    output logic                                  done,
    output logic [chatan_pkg::HEADING_W-1:0]      heading
);

    localparam int CW  = chatan_pkg::COMPONENT_WIDTH;
    localparam int XYW = chatan_pkg::XY_W;
    localparam int AW  = chatan_pkg::ANGLE_W;
    localparam int NR  = chatan_pkg::NUM_ROT;
    localparam int QW  = chatan_pkg::OUT_Q_W;

    logic signed [CW-1:0]  raw_x;
    logic signed [CW-1:0]  raw_y;
    logic signed [XYW-1:0] ext_x;
    logic signed [XYW-1:0] ext_y;
    logic signed [XYW-1:0] x_pre_next;
    logic signed [XYW-1:0] y_pre_next;
    logic signed [AW-1:0]  z_pre_next;
    logic                  zero_pre_next;

    logic signed [XYW-1:0] x_reg    [0:NR];
    logic signed [XYW-1:0] y_reg    [0:NR];
    logic signed [AW-1:0]  z_reg    [0:NR];
    logic                  zero_reg [0:NR];
    logic                  valid_reg [0:NR];

    logic signed [AW-1:0]  z_pos;
    logic signed [AW-1:0]  z_round;
    logic [QW-1:0]         q_next;
    logic [QW-1:0]         q_reg;
    logic                  q_zero_reg;
    logic                  q_valid_reg;
    logic [QW-1:0]         q_wrap;
    logic [chatan_pkg::HEADING_W-1:0] heading_next;
    logic [chatan_pkg::HEADING_W-1:0] heading_reg;
    logic                  done_reg;

    assign busy = 1'b0;

    // field read at the component width
    generate
        if (CW <= chatan_pkg::FIELD_W)
        begin : g_narrow
            assign raw_x = field_x[CW-1:0];
            assign raw_y = field_y[CW-1:0];
        end
        else
        begin : g_wide
            assign raw_x = {{(CW - chatan_pkg::FIELD_W){1'b0}}, field_x};
            assign raw_y = {{(CW - chatan_pkg::FIELD_W){1'b0}}, field_y};
        end
    endgenerate

    assign ext_x = XYW'(raw_x);
    assign ext_y = XYW'(raw_y);

    // fold the left half plane onto the right one
    always_comb
    begin
        zero_pre_next = (raw_x == '0) && (raw_y == '0);
        if (ext_x < 0)
        begin
            x_pre_next = (-ext_x) <<< chatan_pkg::GUARD_BITS;
            y_pre_next = (-ext_y) <<< chatan_pkg::GUARD_BITS;
            z_pre_next = chatan_pkg::HALF_TURN;
        end
        else
        begin
            x_pre_next = ext_x <<< chatan_pkg::GUARD_BITS;
            y_pre_next = ext_y <<< chatan_pkg::GUARD_BITS;
            z_pre_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_pre_next;
        y_reg[0]    <= y_pre_next;
        z_reg[0]    <= z_pre_next;
        zero_reg[0] <= zero_pre_next;
    end

    // micro-rotations, one per stage
    generate
        for (genvar k = 1; k <= NR; k++)
        begin : g_rot
            logic signed [XYW-1:0] x_next;
            logic signed [XYW-1:0] y_next;
            logic signed [AW-1:0]  z_next;

            always_comb
            begin
                if (y_reg[k-1] >= 0)
                begin
                    x_next = x_reg[k-1] + (y_reg[k-1] >>> (k - 1));
                    y_next = y_reg[k-1] - (x_reg[k-1] >>> (k - 1));
                    z_next = z_reg[k-1] + chatan_pkg::ATAN_DEG_Q20[k-1];
                end
                else
                begin
                    x_next = x_reg[k-1] - (y_reg[k-1] >>> (k - 1));
                    y_next = y_reg[k-1] + (x_reg[k-1] >>> (k - 1));
                    z_next = z_reg[k-1] - chatan_pkg::ATAN_DEG_Q20[k-1];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                z_reg[k]    <= z_next;
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    endgenerate

    // normalise to a positive angle and round to 1/128 degree
    always_comb
    begin
        if (z_reg[NR] < 0)
        begin
            z_pos = z_reg[NR] + chatan_pkg::FULL_TURN;
        end
        else
        begin
            z_pos = z_reg[NR];
        end
        z_round = z_pos + chatan_pkg::ROUND_HALF;
        q_next  = z_round[AW-2:chatan_pkg::OUT_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            q_valid_reg <= valid_reg[NR];
            done_reg    <= q_valid_reg;
        end
    end

    // full turn wraps to zero
    always_comb
    begin
        if (q_reg >= chatan_pkg::FULL_TURN_OUT)
        begin
            q_wrap = q_reg - chatan_pkg::FULL_TURN_OUT;
        end
        else
        begin
            q_wrap = q_reg;
        end
        if (q_zero_reg)
        begin
            heading_next = '0;
        end
        else
        begin
            heading_next = q_wrap[chatan_pkg::HEADING_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        q_zero_reg  <= zero_reg[NR];
        heading_reg <= heading_next;
    end

    assign done    = done_reg;
    assign heading = heading_reg;

    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(chatan_pkg::LATENCY) done)
        else $error("accepted item produced no result");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, chatan_pkg::LATENCY))
        else $error("result without an accepted item");

    a_heading_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (heading < chatan_pkg::HEADING_W'(46080)))
        else $error("heading beyond a full turn");

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (field_x == '0) && (field_y == '0))
            |-> ##(chatan_pkg::LATENCY) (heading == '0))
        else $error("zero vector did not give heading zero");

endmodule

### sim/compass_heading_atan2_top_tb.sv
`timescale 1ns / 1ps

module compass_heading_atan2_top_tb;

    localparam int ROT_STAGES   = (chatan_pkg::ANGLE_STAGES < 24) ? chatan_pkg::ANGLE_STAGES : 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int N_DIR        = 21;

    localparam longint HALF_TURN_Q20 = 64'sd180 <<< 20;
    localparam longint FULL_TURN_Q20 = 64'sd360 <<< 20;

    localparam longint ROT_ANGLE_Q20 [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               known;
        logic [15:0]        heading;
    } dir_row_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        heading;
    } heading_exp_t;

    // zero vector rows carry their heading, the rest go through the predictor
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{16'sd0,       16'sd0,       1'b1, 16'd0},
        '{16'sd0,       16'sd0,       1'b1, 16'd0},
        '{16'sd32767,   16'sd0,       1'b0, 16'd0},
        '{-16'sd32768,  16'sd0,       1'b0, 16'd0},
        '{16'sd0,       16'sd32767,   1'b0, 16'd0},
        '{16'sd0,       -16'sd32768,  1'b0, 16'd0},
        '{16'sd32767,   16'sd32767,   1'b0, 16'd0},
        '{-16'sd32768,  -16'sd32768,  1'b0, 16'd0},
        '{16'sd32767,   -16'sd32768,  1'b0, 16'd0},
        '{-16'sd32768,  16'sd32767,   1'b0, 16'd0},
        '{16'sd32767,   -16'sd1,      1'b0, 16'd0},
        '{16'sd32767,   16'sd1,       1'b0, 16'd0},
        '{-16'sd32768,  -16'sd1,      1'b0, 16'd0},
        '{-16'sd32768,  16'sd1,       1'b0, 16'd0},
        '{16'sd1,       16'sd0,       1'b0, 16'd0},
        '{-16'sd1,      16'sd0,       1'b0, 16'd0},
        '{16'sd0,       16'sd1,       1'b0, 16'd0},
        '{16'sd0,       -16'sd1,      1'b0, 16'd0},
        '{16'sd1,       -16'sd1,      1'b0, 16'd0},
        '{-16'sd1,      16'sd1,       1'b0, 16'd0},
        '{-16'sd1,      -16'sd1,      1'b0, 16'd0}
    };

    logic                                  clk;
    logic                                  rst_n;
    logic                                  start;
    logic                                  busy;
    logic signed [chatan_pkg::FIELD_W-1:0] field_x;
    logic signed [chatan_pkg::FIELD_W-1:0] field_y;
    logic                                  done;
    logic [chatan_pkg::HEADING_W-1:0]      heading;

    logic                       row_known;
    logic [15:0]                row_heading;

    heading_exp_t               heading_q [$];
    heading_exp_t               oldest;
    int                         errors;
    int                         n_checked;
    int                         n_zero;
    int                         cycles;

    compass_heading_atan2_top uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .field_x (field_x),
        .field_y (field_y),
        .done    (done),
        .heading (heading)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] predict_heading(logic signed [15:0] fx,
                                                    logic signed [15:0] fy);
        longint          vx;
        longint          vy;
        longint          ang;
        longint          nx;
        longint          ny;
        longint unsigned q;
        vx  = fx;
        vy  = fy;
        ang = 0;
        if (vx == 0 && vy == 0)
        begin
            return 16'd0;
        end
        if (vx < 0)
        begin
            vx  = -vx;
            vy  = -vy;
            ang = HALF_TURN_Q20;
        end
        vx = vx * 256;
        vy = vy * 256;
        for (int i = 0; i < ROT_STAGES; i++)
        begin
            if (vy >= 0)
            begin
                nx  = vx + (vy >>> i);
                ny  = vy - (vx >>> i);
                ang = ang + ROT_ANGLE_Q20[i];
            end
            else
            begin
                nx  = vx - (vy >>> i);
                ny  = vy + (vx >>> i);
                ang = ang - ROT_ANGLE_Q20[i];
            end
            vx = nx;
            vy = ny;
        end
        if (ang < 0)
        begin
            ang = ang + FULL_TURN_Q20;
        end
        q = ($unsigned(ang) + 64'd4096) >> 13;
        while (q >= 64'd46080)
        begin
            q = q - 64'd46080;
        end
        return q[15:0];
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d headings outstanding",
                     cycles, heading_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            heading_q.push_back(heading_exp_t'{field_x, field_y,
                                  row_known ? row_heading : predict_heading(field_x, field_y)});
            if (field_x == 0 && field_y == 0)
            begin
                n_zero <= n_zero + 1;
            end
        end
        if (done)
        begin
            if (heading_q.size() == 0)
            begin
                $display("%0t: unexpected heading %0d with nothing outstanding", $time, heading);
                errors <= errors + 1;
            end
            else
            begin
                oldest = heading_q.pop_front();
                n_checked <= n_checked + 1;
                if (heading !== oldest.heading)
                begin
                    $display("%0t: heading mismatch for x=%0d y=%0d: expected %0d, got %0d",
                             $time, oldest.x, oldest.y, oldest.heading, heading);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic send_item(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic known, input logic [15:0] hd, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        field_x     <= x;
        field_y     <= y;
        row_known   <= known;
        row_heading <= hd;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(4))
            0: return -16'sd32768;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_small();
        return 16'(int'($urandom_range(32)) - 16);
    endfunction

    // mostly full-range vectors, plus near-origin, near-axis and corner ones
    task automatic send_random(input int idle_pct);
        logic signed [15:0] x;
        logic signed [15:0] y;
        case ($urandom_range(9))
            5, 6:
            begin
                x = pick_small();
                y = pick_small();
            end
            7:
            begin
                x = 16'($urandom);
                y = pick_small();
            end
            8:
            begin
                x = pick_small();
                y = 16'($urandom);
            end
            9:
            begin
                x = pick_extreme();
                y = pick_extreme();
            end
            default:
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
        endcase
        send_item(x, y, 1'b0, 16'd0, idle_pct);
    endtask

    // sender idle mixes: none, heavy, none, light
    localparam int IDLE_MIX [4] = '{0, 85, 0, 7};

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        field_x     = '0;
        field_y     = '0;
        row_known   = 1'b0;
        row_heading = '0;
        errors      = 0;
        n_checked   = 0;
        n_zero      = 0;
        cycles      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++)
        begin
            send_item(DIR_ROWS[r].x, DIR_ROWS[r].y, DIR_ROWS[r].known,
                      DIR_ROWS[r].heading, (r < 10) ? 0 : 50);
        end

        for (int p = 0; p < 4; p++)
        begin
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                send_random(IDLE_MIX[p]);
            end
        end
        start <= 1'b0;
        @(posedge clk);

        while (heading_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (chatan_pkg::LATENCY + 4) @(posedge clk);

        $display("checked %0d headings (%0d from zero vectors) under four sender idle mixes",
                 n_checked, n_zero);
        $display("%0d mismatches or stray results", errors);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
